// ===== hw/rtl/tbdeb_pkg.sv =====
// ----------------------------------------------------------------------------
// tbdeb_pkg
// shared constants, types and the pin-to-button map of the button debouncer
// ----------------------------------------------------------------------------
package tbdeb_pkg;

	localparam int NumButtonsDefault = 10;
	localparam int MaxButtons        = 16;
	localparam int OutWidth          = 10;
	localparam int PinWidth          = 16;
	localparam int ThreshWidth       = 8;
	localparam int InDataWidth       = 2 * PinWidth;
	localparam int OutDataWidth      = 32;

	localparam logic [ThreshWidth-1:0] ThreshReset = 8'd5;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic tick;
		logic rd;
		logic out_ready;
	} tbdeb_ctl_t;

	// active-low pins to pressed bits, bits above the wired buttons read released
	function automatic logic [MaxButtons-1:0] pressed_map(
		input logic [PinWidth-1:0] pa,
		input logic [PinWidth-1:0] pb
	);
		logic [OutWidth-1:0] levels;
		levels = {pa[7:4], pa[1], pb[9:5]};
		return MaxButtons'(~levels);
	endfunction

endpackage

// ===== hw/rtl/ten_button_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// ten_button_debouncer_core
// counter-based debouncer for ten active-low buttons with change reporting
// ----------------------------------------------------------------------------
// One item is taken every clock cycle; its result appears in the output
// register on the next cycle. Each button has its own counter lane, so a
// tick updates all buttons at once, and a merge stage forms the change,
// pending and report words. s_tready drops only while a result sits in the
// output register and m_tready is low. The threshold is written over the
// cfg channel, which is always ready.
module ten_button_debouncer_core
	import tbdeb_pkg::*;
#(
	parameter int NUM_BUTTONS = NumButtonsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [ThreshWidth-1:0]  cfg_data,     // debounce_threshold
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [InDataWidth-1:0]  s_tdata,      // port_a_pins, port_b_pins
	input  logic                    s_tuser,      // mode
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OutDataWidth-1:0] m_tdata       // button_state, tick_change, reported_change, zero pad
);

	logic [ThreshWidth-1:0] threshold_q;
	logic [MaxButtons-1:0]  pressed_all;
	logic [NUM_BUTTONS-1:0] stable_q;
	logic [NUM_BUTTONS-1:0] stable_d;
	logic                   in_xfer;
	tbdeb_ctl_t             ctl;
	logic [OutWidth-1:0]    button_state;
	logic [OutWidth-1:0]    tick_change;
	logic [OutWidth-1:0]    reported_change;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ThreshReset;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	assign s_tready      = !m_tvalid || m_tready;
	assign in_xfer       = s_tvalid && s_tready;
	assign ctl.tick      = in_xfer && (s_tuser == MODE_TICK);
	assign ctl.rd        = in_xfer && (s_tuser == MODE_READ);
	assign ctl.out_ready = m_tready;

	assign pressed_all = pressed_map(s_tdata[PinWidth-1:0], s_tdata[2*PinWidth-1:PinWidth]);

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		tbdeb_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (ctl.tick),
			.pressed   (pressed_all[i]),
			.threshold (threshold_q),
			.stable_q  (stable_q[i]),
			.stable_d  (stable_d[i])
		);
	end

	tbdeb_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stable_q        (stable_q),
		.stable_d        (stable_d),
		.out_valid       (m_tvalid),
		.button_state    (button_state),
		.tick_change     (tick_change),
		.reported_change (reported_change)
	);

	assign m_tdata = OutDataWidth'({reported_change, tick_change, button_state});

endmodule

// ===== hw/rtl/tbdeb_lane.sv =====
// ----------------------------------------------------------------------------
// tbdeb_lane
// one button: saturating press counter and debounced status bit
// ----------------------------------------------------------------------------
module tbdeb_lane
	import tbdeb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic                   pressed,
	input  logic [ThreshWidth-1:0] threshold,
	output logic                   stable_q,
	output logic                   stable_d
);

	logic [ThreshWidth-1:0] count_q;
	logic [ThreshWidth-1:0] count_d;
	logic [ThreshWidth-1:0] cap;

	always_comb begin
		cap = (threshold == '1) ? threshold : threshold + ThreshWidth'(1);
		if (!pressed) begin
			count_d = '0;
		end else if (count_q >= cap) begin
			count_d = cap;
		end else begin
			count_d = count_q + ThreshWidth'(1);
		end
		if (count_d > threshold) begin
			stable_d = 1'b1;
		end else if (count_d == '0) begin
			stable_d = 1'b0;
		end else begin
			stable_d = stable_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			stable_q <= 1'b0;
		end else if (tick) begin
			count_q  <= count_d;
			stable_q <= stable_d;
		end
	end

endmodule

// ===== hw/rtl/tbdeb_merge.sv =====
// ----------------------------------------------------------------------------
// tbdeb_merge
// combines the lane status bits into change, pending and report words
// ----------------------------------------------------------------------------
module tbdeb_merge
	import tbdeb_pkg::*;
#(
	parameter int NUM_BUTTONS = NumButtonsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbdeb_ctl_t             ctl,
	input  logic [NUM_BUTTONS-1:0] stable_q,
	input  logic [NUM_BUTTONS-1:0] stable_d,
	output logic                   out_valid,
	output logic [OutWidth-1:0]    button_state,
	output logic [OutWidth-1:0]    tick_change,
	output logic [OutWidth-1:0]    reported_change
);

	logic [NUM_BUTTONS-1:0] change_q;
	logic [NUM_BUTTONS-1:0] pending_q;
	logic [NUM_BUTTONS-1:0] last_q;
	logic [NUM_BUTTONS-1:0] change_d;
	logic                   valid_q;
	logic [OutWidth-1:0]    state_out_q;
	logic [OutWidth-1:0]    change_out_q;
	logic [OutWidth-1:0]    report_out_q;

	function automatic logic [OutWidth-1:0] to_out(input logic [NUM_BUTTONS-1:0] v);
		logic [MaxButtons-1:0] ext;
		ext = MaxButtons'(v);
		return ext[OutWidth-1:0];
	endfunction

	assign change_d = stable_d ^ stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			change_q  <= '0;
			pending_q <= '0;
			last_q    <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (ctl.tick) begin
				change_q  <= change_d;
				pending_q <= pending_q | stable_d;
			end else if (ctl.rd) begin
				pending_q <= '0;
				last_q    <= stable_q;
			end
			if (ctl.tick || ctl.rd) begin
				valid_q <= 1'b1;
			end else if (ctl.out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctl.tick) begin
			state_out_q  <= to_out(stable_d);
			change_out_q <= to_out(change_d);
			report_out_q <= '0;
		end else if (ctl.rd) begin
			state_out_q  <= to_out(stable_q);
			change_out_q <= to_out(change_q);
			report_out_q <= to_out(pending_q ^ last_q);
		end
	end

	assign out_valid       = valid_q;
	assign button_state    = state_out_q;
	assign tick_change     = change_out_q;
	assign reported_change = report_out_q;

endmodule

// ===== hw/rtl/tbdeb_checker.sv =====
// ----------------------------------------------------------------------------
// tbdeb_checker
// port-level checks of the button debouncer, bound to the top level
// ----------------------------------------------------------------------------
module tbdeb_checker
	import tbdeb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [InDataWidth-1:0]  s_tdata,
	input logic                    s_tuser,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [OutDataWidth-1:0] m_tdata
);

	// empty output register always takes a transfer
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("s_tready low with empty output");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after input transfer");

	// stalled result stays put
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_tick_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_TICK) |=> m_tdata[29:20] == '0)
		else $error("tick result carries a report");

	// all wired pins high means every button released
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_TICK) && (s_tdata[7:4] == 4'hF)
		&& s_tdata[1] && (s_tdata[25:21] == 5'h1F) |=> m_tdata[9:0] == '0)
		else $error("released buttons still show pressed");

endmodule

bind ten_button_debouncer_core tbdeb_checker u_tbdeb_checker (.*);
